// File: rtl/sfia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfia_pkg
// Shared types and constants for the lowest-free id allocator.
// ----------------------------------------------------------------------------
package sfia_pkg;

    localparam int MAX_IDS  = 256;
    localparam int ID_W     = 8;
    localparam int WORD_W   = 32;
    localparam int WBIT_W   = $clog2(WORD_W);
    localparam int WORDS    = MAX_IDS / WORD_W;
    localparam int WIDX_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int COUNT_W  = $clog2(MAX_IDS + 1);
    localparam int LIVE_W   = 9;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_REG   = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_QUERY = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_DUP    = 2'd2,
        STAT_ABSENT = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        req_type_t         req_type;
        logic [ID_W-1:0]   entity_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic              is_alive;
        status_t           status;
        logic [LIVE_W-1:0] live_total;
    } rsp_t;

endpackage

// File: rtl/sfia_ffz.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfia_ffz
// Find-first-zero over one presence word, lowest bit position wins.
// ----------------------------------------------------------------------------
module sfia_ffz
    import sfia_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    output logic              found,
    output logic [WBIT_W-1:0] pos
);

    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                found = 1'b1;
                pos   = WBIT_W'(i);
            end
        end
    end

endmodule

// File: rtl/smallest_free_id_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_free_id_allocator_core
// Lowest-free id allocator over a 256-entry presence map.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one response. Register, free and
// query look at the single presence word that holds their id; allocate walks
// the 32-bit presence words in turn with the find-first-zero unit until a
// free id is found or the last word is reached (8 words for 256 ids). The
// response waits in an output register, and a request completes only once
// that register is free.
// ----------------------------------------------------------------------------
module smallest_free_id_allocator_core
    import sfia_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    state_t              state_reg;
    state_t              state_next;
    logic [WORD_W-1:0]   map_reg [WORDS];
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    req_type_t           type_reg;
    logic [ID_W-1:0]     id_reg;
    logic [WIDX_W-1:0]   widx_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic [WORD_W-1:0]   cur_word;
    logic [WORD_W-1:0]   scan_word;
    logic [WORD_W-1:0]   wr_word;
    logic                wr_en;
    logic                ffz_found;
    logic [WBIT_W-1:0]   ffz_pos;
    logic [WBIT_W-1:0]   id_bit;
    logic                in_range;
    logic                id_live;
    logic                last_word;
    logic                done;
    logic                adv;
    logic                rsp_free;
    logic                req_xfer;
    logic                commit;

    assign cur_word  = map_reg[widx_reg];
    assign scan_word = cur_word | ((widx_reg == '0) ? WORD_W'(1) : '0);
    assign id_bit    = WBIT_W'(id_reg);
    assign in_range  = COUNT_W'(id_reg) < COUNT_W'(MAX_IDS);
    assign id_live   = in_range && cur_word[id_bit];
    assign last_word = widx_reg == WIDX_W'(WORDS - 1);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_xfer  = req_valid && !req_stall;
    assign commit    = (state_reg == S_SCAN) && done && rsp_free;

    sfia_ffz u_ffz (
        .word  (scan_word),
        .found (ffz_found),
        .pos   (ffz_pos)
    );

    always_comb
    begin
        done                = 1'b0;
        adv                 = 1'b0;
        wr_en               = 1'b0;
        wr_word             = cur_word;
        count_next          = count_reg;
        rsp_next.result_id  = id_reg;
        rsp_next.is_alive   = 1'b0;
        rsp_next.status     = STAT_OK;
        case (type_reg)
            REQ_ALLOC:
            begin
                rsp_next.result_id = '0;
                if (count_reg == '0)
                begin
                    done              = 1'b1;
                    wr_en             = 1'b1;
                    wr_word           = cur_word | WORD_W'(1);
                    count_next        = count_reg + COUNT_W'(1);
                    rsp_next.is_alive = 1'b1;
                end
                else if (ffz_found)
                begin
                    done               = 1'b1;
                    wr_en              = 1'b1;
                    wr_word            = cur_word | (WORD_W'(1) << ffz_pos);
                    count_next         = count_reg + COUNT_W'(1);
                    rsp_next.result_id = ID_W'({widx_reg, ffz_pos});
                    rsp_next.is_alive  = 1'b1;
                end
                else if (last_word)
                begin
                    done            = 1'b1;
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            REQ_REG:
            begin
                done = 1'b1;
                if (!in_range)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else if (cur_word[id_bit])
                begin
                    rsp_next.status   = STAT_DUP;
                    rsp_next.is_alive = 1'b1;
                end
                else
                begin
                    wr_en             = 1'b1;
                    wr_word           = cur_word | (WORD_W'(1) << id_bit);
                    count_next        = count_reg + COUNT_W'(1);
                    rsp_next.is_alive = 1'b1;
                end
            end
            REQ_FREE:
            begin
                done = 1'b1;
                if (id_live)
                begin
                    wr_en      = 1'b1;
                    wr_word    = cur_word & ~(WORD_W'(1) << id_bit);
                    count_next = count_reg - COUNT_W'(1);
                end
                else
                begin
                    rsp_next.status = STAT_ABSENT;
                end
            end
            REQ_QUERY:
            begin
                done              = 1'b1;
                rsp_next.is_alive = id_live;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        rsp_next.live_total = LIVE_W'(count_next);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall = (state_reg != S_IDLE);
        rsp_valid = rsp_valid_reg;
        rsp_data  = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < WORDS; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
                if (wr_en)
                begin
                    map_reg[widx_reg] <= wr_word;
                end
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            type_reg <= req_data.req_type;
            id_reg   <= req_data.entity_id;
            if (req_data.req_type == REQ_ALLOC)
            begin
                widx_reg <= '0;
            end
            else
            begin
                widx_reg <= WIDX_W'(req_data.entity_id >> WBIT_W);
            end
        end
        else if ((state_reg == S_SCAN) && adv)
        begin
            widx_reg <= widx_reg + WIDX_W'(1);
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: rtl/sfia_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfia_chk
// Port-level checks for the lowest-free id allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sfia_chk
    import sfia_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_data
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.live_total <= LIVE_W'(MAX_IDS))
        else $error("live count beyond id space");

    a_fail_not_alive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == STAT_FULL || rsp_data.status == STAT_ABSENT)
        |-> !rsp_data.is_alive)
        else $error("failed request reports live id");

    a_dup_alive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == STAT_DUP |-> rsp_data.is_alive)
        else $error("duplicate register reports dead id");

endmodule

bind smallest_free_id_allocator_core sfia_chk u_sfia_chk (.*);

// File: verif/sfia_response_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfia_response_checker
// Predicts and checks every response of the lowest-free id allocator.
// ----------------------------------------------------------------------------
// Watches both channels of the block. Each accepted request goes through a
// private copy of the presence map and the live count, and the response that
// it must produce is queued. Each accepted response is compared field by
// field with the oldest queued one. The failure and pending counts go to the
// testbench top.
// ----------------------------------------------------------------------------
module sfia_response_checker
    import sfia_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp_data,
    output int   fail_count,
    output int   pending,
    output int   full_count,
    output int   dup_count
);

    bit                id_live [MAX_IDS];
    logic [LIVE_W-1:0] live_ids;
    rsp_t              expected_rsps [$];

    function automatic rsp_t serve_request(req_t r);
        rsp_t o;
        int   slot;
        bit   in_range;
        in_range    = int'(r.entity_id) < MAX_IDS;
        o.result_id = r.entity_id;
        o.is_alive  = 1'b0;
        o.status    = STAT_OK;
        case (r.req_type)
            REQ_ALLOC:
            begin
                if (live_ids == '0)
                begin
                    o.result_id = '0;
                    id_live[0]  = 1'b1;
                    live_ids    = live_ids + 1'b1;
                    o.is_alive  = 1'b1;
                end
                else
                begin
                    slot = 1;
                    while (slot < MAX_IDS && id_live[slot])
                        slot++;
                    if (slot < MAX_IDS)
                    begin
                        o.result_id   = ID_W'(slot);
                        id_live[slot] = 1'b1;
                        live_ids      = live_ids + 1'b1;
                        o.is_alive    = 1'b1;
                    end
                    else
                    begin
                        o.result_id = '0;
                        o.status    = STAT_FULL;
                    end
                end
            end
            REQ_REG:
            begin
                if (!in_range)
                    o.status = STAT_FULL;
                else if (id_live[r.entity_id])
                begin
                    o.status   = STAT_DUP;
                    o.is_alive = 1'b1;
                end
                else
                begin
                    id_live[r.entity_id] = 1'b1;
                    live_ids             = live_ids + 1'b1;
                    o.is_alive           = 1'b1;
                end
            end
            REQ_FREE:
            begin
                if (in_range && id_live[r.entity_id])
                begin
                    id_live[r.entity_id] = 1'b0;
                    live_ids             = live_ids - 1'b1;
                end
                else
                    o.status = STAT_ABSENT;
            end
            default:
            begin
                o.is_alive = in_range && id_live[r.entity_id];
            end
        endcase
        o.live_total = live_ids;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_t want;
        int   errs;
        errs = 0;
        if (!rst_n)
        begin
            foreach (id_live[i])
                id_live[i] = 1'b0;
            live_ids = '0;
            expected_rsps.delete();
            fail_count <= 0;
            pending    <= 0;
            full_count <= 0;
            dup_count  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response with nothing outstanding: result_id %0d status %0d",
                           rsp_data.result_id, rsp_data.status);
                    errs++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_data.result_id !== want.result_id)
                    begin
                        $error("result_id: expected %0d, got %0d",
                               want.result_id, rsp_data.result_id);
                        errs++;
                    end
                    if (rsp_data.is_alive !== want.is_alive)
                    begin
                        $error("is_alive: expected %0d, got %0d",
                               want.is_alive, rsp_data.is_alive);
                        errs++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp_data.status);
                        errs++;
                    end
                    if (rsp_data.live_total !== want.live_total)
                    begin
                        $error("live_total: expected %0d, got %0d",
                               want.live_total, rsp_data.live_total);
                        errs++;
                    end
                    if (want.status == STAT_FULL)
                        full_count <= full_count + 1;
                    if (want.status == STAT_DUP)
                        dup_count <= dup_count + 1;
                end
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(serve_request(req_data));
            fail_count <= fail_count + errs;
            pending    <= expected_rsps.size();
        end
    end

endmodule

// File: verif/tb_smallest_free_id_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smallest_free_id_allocator_core
// Self-checking testbench for the lowest-free id allocator.
// ----------------------------------------------------------------------------
// Sends a short directed list of requests (empty map, reuse of freed ids,
// id 0 not handed out again, duplicate register, free of an absent id),
// then random traffic built from fill runs that drive the map to full,
// drain runs, register runs and mixed requests. The sender works in bursts
// with random gaps and the receiver stalls on its own pattern. A separate
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_smallest_free_id_allocator_core;
    import sfia_pkg::*;

    localparam int ITEMS        = 1700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        STALL_NONE  = 0,
        STALL_COIN  = 1,
        STALL_HEAVY = 2,
        STALL_SOLID = 3
    } stall_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    req_t        req_data  = '0;
    logic        rsp_stall = 1'b0;
    logic        req_stall;
    logic        rsp_valid;
    rsp_t        rsp_data;

    int          fail_count;
    int          pending;
    int          full_count;
    int          dup_count;
    int          sent;
    int          sent_by_kind [4];
    int          burst_left;
    int          idle_cycles;
    int          stall_left;
    stall_mode_t stall_mode;

    smallest_free_id_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    sfia_response_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending),
        .full_count (full_count),
        .dup_count  (dup_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(4, 60);
            rsp_stall  <= 1'b0;
        end
        else
        begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
                STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
                default:     rsp_stall <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d responses pending",
                     IDLE_LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(input req_type_t kind, input logic [ID_W-1:0] id);
        req_t item;
        int   gap;
        item.req_type  = kind;
        item.entity_id = id;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
        sent_by_kind[kind]++;
    endtask

    task automatic send_mixed(input int base);
        req_type_t kind;
        int        pick;
        int        id;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            kind = REQ_ALLOC;
        else if (pick < 55)
            kind = REQ_REG;
        else if (pick < 80)
            kind = REQ_FREE;
        else
            kind = REQ_QUERY;
        case ($urandom_range(0, 2))
            0:       id = $urandom_range(0, 15);
            1:       id = base + $urandom_range(0, 31);
            default: id = $urandom_range(0, 255);
        endcase
        send_request(kind, ID_W'(id));
    endtask

    initial
    begin : stimulus
        int scenario;
        int base;
        int fills;
        fills      = 0;
        sent       = 0;
        burst_left = 0;
        foreach (sent_by_kind[i])
            sent_by_kind[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty map, id 0 first, freed id 0 not reused, duplicates, absent frees
        send_request(REQ_QUERY, 8'd0);
        send_request(REQ_FREE,  8'd0);
        send_request(REQ_ALLOC, 8'hff);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_ALLOC, 8'h5a);
        send_request(REQ_REG,   8'hff);
        send_request(REQ_REG,   8'hff);
        send_request(REQ_QUERY, 8'hff);
        send_request(REQ_FREE,  8'd0);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_FREE,  8'd1);
        send_request(REQ_ALLOC, 8'd7);
        send_request(REQ_QUERY, 8'd1);
        send_request(REQ_REG,   8'd0);
        send_request(REQ_FREE,  8'hff);
        send_request(REQ_FREE,  8'hff);
        send_request(REQ_QUERY, 8'haa);
        send_request(REQ_REG,   8'h55);
        send_request(REQ_QUERY, 8'h55);
        send_request(REQ_FREE,  8'haa);
        send_request(REQ_REG,   8'h80);
        send_request(REQ_QUERY, 8'h7f);

        while (sent < ITEMS)
        begin
            scenario = $urandom_range(0, 19);
            base     = $urandom_range(0, 255);
            if (fills < 2 && (scenario == 0 || (fills == 0 && sent > 400)))
            begin
                fills++;
                repeat (260) send_request(REQ_ALLOC, ID_W'($urandom));
                repeat (8) send_mixed(base);
            end
            else if (scenario < 4)
            begin
                for (int k = 0; k < 48; k++)
                    send_request(REQ_FREE, ID_W'(base + k));
            end
            else if (scenario < 7)
            begin
                repeat (24) send_request(REQ_REG, ID_W'(base + $urandom_range(0, 15)));
            end
            else
            begin
                repeat (24) send_mixed(base);
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d allocate, %0d register, %0d free, %0d query",
                 sent, sent_by_kind[REQ_ALLOC], sent_by_kind[REQ_REG],
                 sent_by_kind[REQ_FREE], sent_by_kind[REQ_QUERY]);
        $display("map reported full %0d times, duplicate registers seen %0d times",
                 full_count, dup_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
